[rtl/pre80_pkg.sv]
`default_nettype none

package pre80_pkg;

  localparam int unsigned BlockW = 64;
  localparam int unsigned KeyW   = 80;
  localparam int unsigned RndW   = 5;

  // Configuration register selects, taken from address bit 3.
  localparam logic REG_KEY_LOW  = 1'b0;
  localparam logic REG_KEY_HIGH = 1'b1;

  localparam logic [3:0] SBOX [16] = '{
    4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA, 4'hD,
    4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
  };

  // What one cell hands to the next.
  typedef struct packed {
    logic              valid;
    logic [BlockW-1:0] state;
    logic [KeyW-1:0]   key;
  } cell_t;

  function automatic logic [BlockW-1:0] sub_layer(input logic [BlockW-1:0] s);
    logic [BlockW-1:0] r;
    r = '0;
    for (int n = 0; n < 16; n++) begin
      r[4*n +: 4] = SBOX[s[4*n +: 4]];
    end
    return r;
  endfunction

  // Bit i moves to i/4 + (i%4)*16.
  function automatic logic [BlockW-1:0] perm_layer(input logic [BlockW-1:0] s);
    logic [BlockW-1:0] r;
    r = '0;
    for (int i = 0; i < 64; i++) begin
      r[(i / 4) + (i % 4) * 16] = s[i];
    end
    return r;
  endfunction

  // Rotate left by 61, substitute the top nibble, fold in the round number.
  function automatic logic [KeyW-1:0] key_update(input logic [KeyW-1:0] k,
                                                 input logic [RndW-1:0] rnd);
    logic [KeyW-1:0] r;
    r = {k[18:0], k[79:19]};
    r[79:76] = SBOX[r[79:76]];
    r[19:15] = r[19:15] ^ rnd;
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/present80_block_encrypt.sv]
`default_nettype none

// PRESENT-80 block encryption, one 64-bit word in and one out.
//
// Input channel: a plaintext word is taken on a rising edge with start_i
// high and busy_o low. busy_o is never raised, so a new word may be offered
// on every cycle.
// Output channel: the ciphertext is shown on ciphertext_o for exactly one
// cycle, marked by valid_o. The receiver cannot hold it off, and none is
// needed: results leave in the order their words came in.
// A word passes through a register in each round cell of the chain and then
// through the output register that adds the last round key. Throughput is
// one word per cycle, set by the chain of round cells, each holding one word
// and its round key and passing both on to the next cell every cycle.
// Configuration: the 80-bit key sits in two registers on the APB-style port,
// key_low at byte address 0 and key_high at 8. Write the key only while no
// word is in flight; every word starts from the key as written.
// Reset clears both key registers and every valid flag in the chain, so no
// spurious result follows reset.
module present80_block_encrypt #(
  parameter int unsigned ROUNDS = 31
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [63:0] plaintext_i,
  output logic             valid_o,
  output logic [63:0]      ciphertext_o,
  input  wire logic        psel_i,
  input  wire logic        penable_i,
  input  wire logic        pwrite_i,
  input  wire logic [3:0]  paddr_i,
  input  wire logic [63:0] pwdata_i,
  output logic [63:0]      prdata_o,
  output logic             pready_o
);
  import pre80_pkg::*;

  // Key registers.
  logic [63:0] key_low_d, key_low_q;
  logic [15:0] key_high_d, key_high_q;
  logic        reg_sel;
  logic        wr_en;

  // Only address bit 3 picks the register; the lower bits are ignored.
  assign reg_sel  = paddr_i[3];
  assign wr_en    = psel_i & penable_i & pwrite_i & pready_o;
  assign pready_o = 1'b1;

  always_comb begin
    key_low_d  = key_low_q;
    key_high_d = key_high_q;
    if (wr_en) begin
      unique case (reg_sel)
        REG_KEY_LOW:  key_low_d  = pwdata_i;
        REG_KEY_HIGH: key_high_d = pwdata_i[15:0];
        default:      key_low_d  = key_low_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_KEY_LOW:  prdata_o = key_low_q;
      REG_KEY_HIGH: prdata_o = {48'd0, key_high_q};
      default:      prdata_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_high_q <= '0;
    end else begin
      key_low_q  <= key_low_d;
      key_high_q <= key_high_d;
    end
  end

  // The chain never stalls, so it can always take a word.
  assign busy_o = 1'b0;

  // Link k feeds the cell for round k+1; the last link carries the state
  // after all rounds together with the final round key.
  cell_t link [ROUNDS+1];

  assign link[0].valid = start_i & ~busy_o;
  assign link[0].state = plaintext_i;
  assign link[0].key   = {key_high_q, key_low_q};

  for (genvar r = 0; r < ROUNDS; r++) begin : g_round
    pre80_round_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .rnd_i  (RndW'(r + 1)),
      .cell_i (link[r]),
      .cell_o (link[r+1])
    );
  end

  // Output register with the final key addition.
  logic        out_valid_d, out_valid_q;
  logic [63:0] out_data_d, out_data_q;

  always_comb begin
    out_valid_d = link[ROUNDS].valid;
    out_data_d  = link[ROUNDS].state ^ link[ROUNDS].key[KeyW-1 -: BlockW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign valid_o      = out_valid_q;
  assign ciphertext_o = out_data_q;

endmodule

`default_nettype wire

[rtl/pre80_round_cell.sv]
`default_nettype none

module pre80_round_cell (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [pre80_pkg::RndW-1:0] rnd_i,
  input  wire pre80_pkg::cell_t           cell_i,
  output pre80_pkg::cell_t                cell_o
);
  import pre80_pkg::*;

  logic              valid_d, valid_q;
  logic [BlockW-1:0] state_d, state_q;
  logic [KeyW-1:0]   key_d, key_q;

  always_comb begin
    valid_d = cell_i.valid;
    state_d = perm_layer(sub_layer(cell_i.state ^ cell_i.key[KeyW-1 -: BlockW]));
    key_d   = key_update(cell_i.key, rnd_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    state_q <= state_d;
    key_q   <= key_d;
  end

  assign cell_o.valid = valid_q;
  assign cell_o.state = state_q;
  assign cell_o.key   = key_q;

endmodule

`default_nettype wire
